// File: hdl/lgs_pkg.sv
// Shared types and constants for the life generation step block.
// Used by life_generation_step_top and its testbench; depends on nothing.
package lgs_pkg;

  localparam int ROWS_DEF = 128;
  localparam int COLS_DEF = 128;

  localparam int CMD_W = 2;
  localparam int ROW_W = 7;
  localparam int COL_W = 7;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b0_0000_0001,
    ST_IDLE      = 9'b0_0000_0010,
    ST_WR_WB     = 9'b0_0000_0100,
    ST_RD_OUT    = 9'b0_0000_1000,
    ST_ADV_LD0   = 9'b0_0001_0000,
    ST_ROW_FETCH = 9'b0_0010_0000,
    ST_ROW_LOAD  = 9'b0_0100_0000,
    ST_CELL      = 9'b0_1000_0000,
    ST_ROW_WB    = 9'b1_0000_0000
  } lgs_state_t;

endpackage

// File: hdl/life_generation_step_top.sv
// Top level of the life generation step block (rule B3/S23, no wrap).
// Depends on lgs_pkg and lgs_ram; the board is one lgs_ram, one row per word.
//
// A command is taken when start is high and busy is low; its result appears on
// out_kind/out_cell_alive for exactly one cycle with out_valid high, and the
// receiver cannot stall it. After reset the block is busy
// while it clears the board one row per cycle. Write and read keep busy high
// for one cycle (one row read, then the row write-back or the bit select) and
// answer in the cycle after. Command 3 answers in the next cycle. Advance keeps
// busy high while one shared neighbor-count and rule unit visits one cell per
// cycle from a three-row window, and each row adds a read, a load and a
// write-back on the single board memory port pair.
module life_generation_step_top #(
  parameter int ROWS = lgs_pkg::ROWS_DEF,
  parameter int COLS = lgs_pkg::COLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [lgs_pkg::CMD_W-1:0] in_command,
  input  logic [lgs_pkg::ROW_W-1:0] in_row,
  input  logic [lgs_pkg::COL_W-1:0] in_col,
  input  logic                      in_value,
  output logic                      out_valid,
  output logic [lgs_pkg::CMD_W-1:0] out_kind,
  output logic                      out_cell_alive
);

  localparam int ROW_AW = $clog2(ROWS);
  localparam int COL_AW = $clog2(COLS);
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
  localparam logic [COL_AW-1:0] COL_LAST = COL_AW'(COLS - 1);

  lgs_pkg::lgs_state_t state_r, state_nxt;

  logic [ROW_AW-1:0] r_r, r_nxt;
  logic [COL_AW-1:0] c_r, c_nxt;
  logic [COLS-1:0]   above_r, above_nxt;
  logic [COLS-1:0]   cur_r, cur_nxt;
  logic [COLS-1:0]   below_r, below_nxt;
  logic [COLS-1:0]   new_r, new_nxt;
  logic              left_a_r, left_a_nxt;
  logic              left_c_r, left_c_nxt;
  logic              left_b_r, left_b_nxt;
  logic [COL_AW-1:0] col_r, col_nxt;
  logic              val_r, val_nxt;
  logic              ok_r, ok_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [lgs_pkg::CMD_W-1:0] out_kind_r, out_kind_nxt;
  logic                      out_alive_r, out_alive_nxt;

  logic              ram_wr_en;
  logic [ROW_AW-1:0] ram_wr_addr;
  logic [COLS-1:0]   ram_wr_data;
  logic              ram_rd_en;
  logic [ROW_AW-1:0] ram_rd_addr;
  logic [COLS-1:0]   ram_rd_data;

  logic              accept;
  logic [31:0]       in_row_ext;
  logic [31:0]       in_col_ext;
  logic              in_ok;
  logic              right_ok;
  logic [3:0]        nbr_cnt;
  logic              cell_next;
  logic [COLS-1:0]   patched_row;

  assign busy       = (state_r != lgs_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign in_row_ext = 32'(in_row);
  assign in_col_ext = 32'(in_col);
  assign in_ok      = (in_row_ext < 32'(ROWS)) && (in_col_ext < 32'(COLS));

  // Shared cell unit: window column c sits at bit 0, c+1 at bit 1, c-1 in the left regs.
  assign right_ok  = (c_r != COL_LAST);
  assign nbr_cnt   = 4'(left_a_r) + 4'(left_c_r) + 4'(left_b_r)
                   + 4'(above_r[0]) + 4'(below_r[0])
                   + 4'(above_r[1] & right_ok) + 4'(cur_r[1] & right_ok)
                   + 4'(below_r[1] & right_ok);
  assign cell_next = (nbr_cnt == 4'd3) || (cur_r[0] && (nbr_cnt == 4'd2));

  always_comb begin
    patched_row = ram_rd_data;
    patched_row[col_r] = val_r;
  end

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    below_nxt     = below_r;
    new_nxt       = new_r;
    left_a_nxt    = left_a_r;
    left_c_nxt    = left_c_r;
    left_b_nxt    = left_b_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_alive_nxt = out_alive_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = r_r;
    ram_wr_data   = new_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = in_row_ext[ROW_AW-1:0];

    case (state_r)
      lgs_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = '0;
        r_nxt       = r_r + 1'b1;
        if (r_r == ROW_LAST) begin
          r_nxt     = '0;
          state_nxt = lgs_pkg::ST_IDLE;
        end
      end

      lgs_pkg::ST_IDLE: begin
        if (accept) begin
          col_nxt      = in_col_ext[COL_AW-1:0];
          val_nxt      = in_value;
          ok_nxt       = in_ok;
          out_kind_nxt = in_command;
          case (in_command)
            lgs_pkg::CMD_WRITE: begin
              // hold the row for the write-back
              ram_rd_en = 1'b1;
              r_nxt     = in_row_ext[ROW_AW-1:0];
              state_nxt = lgs_pkg::ST_WR_WB;
            end
            lgs_pkg::CMD_READ: begin
              ram_rd_en = 1'b1;
              state_nxt = lgs_pkg::ST_RD_OUT;
            end
            lgs_pkg::CMD_ADVANCE: begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              above_nxt   = '0;
              r_nxt       = '0;
              state_nxt   = lgs_pkg::ST_ADV_LD0;
            end
            default: begin
              // unused command: answer right away, touch nothing
              out_valid_nxt = 1'b1;
              out_alive_nxt = 1'b0;
            end
          endcase
        end
      end

      lgs_pkg::ST_WR_WB: begin
        ram_wr_en     = ok_r;
        ram_wr_addr   = r_r;
        ram_wr_data   = patched_row;
        out_valid_nxt = 1'b1;
        out_alive_nxt = 1'b0;
        state_nxt     = lgs_pkg::ST_IDLE;
      end

      lgs_pkg::ST_RD_OUT: begin
        out_valid_nxt = 1'b1;
        out_alive_nxt = ok_r & ram_rd_data[col_r];
        state_nxt     = lgs_pkg::ST_IDLE;
      end

      lgs_pkg::ST_ADV_LD0: begin
        cur_nxt   = ram_rd_data;
        state_nxt = lgs_pkg::ST_ROW_FETCH;
      end

      lgs_pkg::ST_ROW_FETCH: begin
        ram_rd_en   = (r_r != ROW_LAST);
        ram_rd_addr = r_r + 1'b1;
        state_nxt   = lgs_pkg::ST_ROW_LOAD;
      end

      lgs_pkg::ST_ROW_LOAD: begin
        below_nxt  = (r_r == ROW_LAST) ? '0 : ram_rd_data;
        c_nxt      = '0;
        left_a_nxt = 1'b0;
        left_c_nxt = 1'b0;
        left_b_nxt = 1'b0;
        state_nxt  = lgs_pkg::ST_CELL;
      end

      lgs_pkg::ST_CELL: begin
        // rotate the window so the rows are intact again after COLS steps
        new_nxt    = {cell_next, new_r[COLS-1:1]};
        above_nxt  = {above_r[0], above_r[COLS-1:1]};
        cur_nxt    = {cur_r[0], cur_r[COLS-1:1]};
        below_nxt  = {below_r[0], below_r[COLS-1:1]};
        left_a_nxt = above_r[0];
        left_c_nxt = cur_r[0];
        left_b_nxt = below_r[0];
        c_nxt      = c_r + 1'b1;
        if (c_r == COL_LAST) begin
          state_nxt = lgs_pkg::ST_ROW_WB;
        end
      end

      lgs_pkg::ST_ROW_WB: begin
        // row r+1 is already held, so write the new row in place
        ram_wr_en   = 1'b1;
        ram_wr_addr = r_r;
        ram_wr_data = new_r;
        above_nxt   = cur_r;
        cur_nxt     = below_r;
        if (r_r == ROW_LAST) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = 1'b0;
          state_nxt     = lgs_pkg::ST_IDLE;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = lgs_pkg::ST_ROW_FETCH;
        end
      end

      default: begin
        state_nxt = lgs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgs_pkg::ST_CLEAR;
      r_r         <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    above_r     <= above_nxt;
    cur_r       <= cur_nxt;
    below_r     <= below_nxt;
    new_r       <= new_nxt;
    left_a_r    <= left_a_nxt;
    left_c_r    <= left_c_nxt;
    left_b_r    <= left_b_nxt;
    col_r       <= col_nxt;
    val_r       <= val_nxt;
    ok_r        <= ok_nxt;
    out_kind_r  <= out_kind_nxt;
    out_alive_r <= out_alive_nxt;
  end

  lgs_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_board (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_cell_alive = out_alive_r;

endmodule

// File: hdl/lgs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module lgs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: verif/tb_life_generation_step_top.sv
// Self-checking testbench for life_generation_step_top: cell write, cell read, unused code
// and generation advance (B3/S23, no wrap), checked against an in-bench board predictor.
// Depends on lgs_pkg for command codes, widths and board size.
module tb_life_generation_step_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W = lgs_pkg::CMD_W;
  localparam int ROW_W = lgs_pkg::ROW_W;
  localparam int COL_W = lgs_pkg::COL_W;
  localparam logic [CMD_W-1:0] CMD_WRITE   = lgs_pkg::CMD_WRITE;
  localparam logic [CMD_W-1:0] CMD_READ    = lgs_pkg::CMD_READ;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = lgs_pkg::CMD_ADVANCE;

  localparam int GRID_ROWS = lgs_pkg::ROWS_DEF;
  localparam int GRID_COLS = lgs_pkg::COLS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 70;
  localparam int MAX_RANDOM_ADVANCES = 20;

  typedef struct packed {
    logic [CMD_W-1:0] kind;
    logic             alive;
  } life_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             val;
    logic             typed;
    logic             alive;
  } life_stim_t;

  // Directed table: typed rows carry their answer, the rest go to the predictor.
  localparam int DIR_COUNT = 25;
  localparam life_stim_t DIR_TABLE [DIR_COUNT] = '{
    '{CMD_READ,    7'd0,   7'd0,   1'b0, 1'b1, 1'b0},  // board clear after reset
    '{CMD_READ,    7'd127, 7'd127, 1'b1, 1'b1, 1'b0},
    '{CMD_UNUSED,  7'd127, 7'd127, 1'b1, 1'b1, 1'b0},
    '{CMD_WRITE,   7'd0,   7'd0,   1'b1, 1'b1, 1'b0},
    '{CMD_READ,    7'd0,   7'd0,   1'b0, 1'b1, 1'b1},
    '{CMD_WRITE,   7'd0,   7'd0,   1'b0, 1'b1, 1'b0},
    '{CMD_READ,    7'd0,   7'd0,   1'b1, 1'b1, 1'b0},
    // blinker lying on the bottom edge, block in the far corner
    '{CMD_WRITE,   7'd127, 7'd0,   1'b1, 1'b0, 1'b0},
    '{CMD_WRITE,   7'd127, 7'd1,   1'b1, 1'b0, 1'b0},
    '{CMD_WRITE,   7'd127, 7'd2,   1'b1, 1'b0, 1'b0},
    '{CMD_WRITE,   7'd126, 7'd126, 1'b1, 1'b0, 1'b0},
    '{CMD_WRITE,   7'd126, 7'd127, 1'b1, 1'b0, 1'b0},
    '{CMD_WRITE,   7'd127, 7'd126, 1'b1, 1'b0, 1'b0},
    '{CMD_WRITE,   7'd127, 7'd127, 1'b1, 1'b0, 1'b0},
    '{CMD_ADVANCE, 7'd0,   7'd0,   1'b1, 1'b1, 1'b0},
    '{CMD_READ,    7'd126, 7'd1,   1'b0, 1'b0, 1'b0},
    '{CMD_READ,    7'd127, 7'd0,   1'b0, 1'b0, 1'b0},
    '{CMD_READ,    7'd127, 7'd1,   1'b0, 1'b0, 1'b0},
    '{CMD_READ,    7'd127, 7'd127, 1'b0, 1'b0, 1'b0},
    // lone cells die of isolation, one in the top right corner
    '{CMD_WRITE,   7'd64,  7'd64,  1'b1, 1'b0, 1'b0},
    '{CMD_WRITE,   7'd0,   7'd127, 1'b1, 1'b0, 1'b0},
    '{CMD_ADVANCE, 7'd127, 7'd127, 1'b0, 1'b0, 1'b0},
    '{CMD_READ,    7'd64,  7'd64,  1'b0, 1'b0, 1'b0},
    '{CMD_READ,    7'd0,   7'd127, 1'b0, 1'b0, 1'b0},
    '{CMD_READ,    7'd126, 7'd127, 1'b0, 1'b0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [CMD_W-1:0] in_command;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_value;
  logic             out_valid;
  logic [CMD_W-1:0] out_kind;
  logic             out_cell_alive;

  logic         board_model [GRID_ROWS][GRID_COLS];
  logic         next_model  [GRID_ROWS][GRID_COLS];
  life_result_t pending_results [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  writes_sent = 0;
  int  reads_sent = 0;
  int  advances_sent = 0;
  int  unused_sent = 0;
  int  live_reads_seen = 0;
  int  results_seen = 0;
  bit  no_idle = 1'b0;

  life_generation_step_top #(
    .ROWS(GRID_ROWS),
    .COLS(GRID_COLS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_cell_alive(out_cell_alive)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic cell_state(int r, int c);
    if (r < 0 || c < 0 || r >= GRID_ROWS || c >= GRID_COLS) return 1'b0;
    return board_model[r][c];
  endfunction

  function automatic void step_generation();
    int n;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += cell_state(r + dr, c + dc);
          end
        end
        next_model[r][c] = board_model[r][c] ? (n == 2 || n == 3) : (n == 3);
      end
    end
    board_model = next_model;
  endfunction

  function automatic life_result_t predict_command(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col, logic val);
    life_result_t res;
    res.kind = cmd;
    res.alive = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        if (row < GRID_ROWS && col < GRID_COLS) board_model[row][col] = val;
      end
      CMD_READ: begin
        res.alive = cell_state(int'(row), int'(col));
      end
      CMD_ADVANCE: begin
        step_generation();
      end
      default: ;
    endcase
    return res;
  endfunction

  // Present one transaction and hold it until it is taken; start may drop on idle cycles.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col, input logic val,
                               input bit typed, input logic typed_alive);
    life_result_t predicted;
    bit           taken;
    taken = 1'b0;
    in_command <= cmd;
    in_row     <= row;
    in_col     <= col;
    in_value   <= val;
    while (!taken) begin
      if (!no_idle && $urandom_range(0, 99) < 26) start <= 1'b0;
      else start <= 1'b1;
      @(posedge clk);
      taken = start && !busy;
    end
    predicted = predict_command(cmd, row, col, val);
    if (typed) begin
      predicted.kind  = cmd;
      predicted.alive = typed_alive;
    end
    pending_results.push_back(predicted);
    case (cmd)
      CMD_WRITE:   writes_sent++;
      CMD_READ:    reads_sent++;
      CMD_ADVANCE: advances_sent++;
      default:     unused_sent++;
    endcase
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [ROW_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 7'd120;
      default: return 7'($urandom_range(0, 120));
    endcase
  endfunction

  always @(posedge clk) begin
    life_result_t exp_res;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_cell_alive) live_reads_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d cell_alive %0d", out_kind, out_cell_alive);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_kind !== exp_res.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", exp_res.kind, out_kind);
          mismatch_count++;
        end
        if (out_cell_alive !== exp_res.alive) begin
          $error("cell_alive mismatch: expected %0d, actual %0d", exp_res.alive, out_cell_alive);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_life_generation_step_top failed");
      $finish;
    end
  end

  initial begin
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    int               sent;
    int               random_advances;
    int               n_ops;

    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_command <= CMD_WRITE;
    in_row     <= '0;
    in_col     <= '0;
    in_value   <= 1'b0;
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++) begin
        board_model[r][c] = 1'b0;
        next_model[r][c]  = 1'b0;
      end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_COUNT; i++)
      issue_command(DIR_TABLE[i].cmd, DIR_TABLE[i].row, DIR_TABLE[i].col, DIR_TABLE[i].val,
                    DIR_TABLE[i].typed, DIR_TABLE[i].alive);

    // hold off until the board has answered everything
    wait_drained();

    sent = 0;
    random_advances = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = (sent >= 30 && sent < 60);
      if ($urandom_range(0, 9) == 0) begin
        // noise: write, read or unused command, full-range coordinates
        n_ops = $urandom_range(1, 3);
        for (int k = 0; k < n_ops; k++) begin
          logic [CMD_W-1:0] cmd;
          cmd = CMD_W'($urandom_range(0, 3));
          if (cmd == CMD_ADVANCE) cmd = CMD_UNUSED;
          issue_command(cmd, ROW_W'($urandom_range(0, 127)), COL_W'($urandom_range(0, 127)),
                        1'($urandom_range(0, 1)), 1'b0, 1'b0);
          sent++;
        end
      end else begin
        // seed a small window, maybe evolve it, then probe it
        r0 = pick_origin();
        c0 = pick_origin();
        n_ops = $urandom_range(4, 10);
        for (int k = 0; k < n_ops; k++) begin
          issue_command(CMD_WRITE, r0 + ROW_W'($urandom_range(0, 7)),
                        c0 + COL_W'($urandom_range(0, 7)),
                        ($urandom_range(0, 9) < 7), 1'b0, 1'b0);
          sent++;
        end
        n_ops = (random_advances < MAX_RANDOM_ADVANCES) ? $urandom_range(0, 2) : 0;
        for (int k = 0; k < n_ops; k++) begin
          issue_command(CMD_ADVANCE, ROW_W'($urandom_range(0, 127)),
                        COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
          random_advances++;
          sent++;
        end
        n_ops = $urandom_range(3, 8);
        for (int k = 0; k < n_ops; k++) begin
          issue_command(CMD_READ, r0 + ROW_W'($urandom_range(0, 7)),
                        c0 + COL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                        1'b0, 1'b0);
          sent++;
        end
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end

    $display("run covered %0d writes, %0d reads, %0d generation steps, %0d unused codes",
             writes_sent, reads_sent, advances_sent, unused_sent);
    $display("%0d results checked, %0d reads found a live cell", results_seen, live_reads_seen);
    if (mismatch_count == 0) begin
      $display("tb_life_generation_step_top passed");
    end else begin
      $display("tb_life_generation_step_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lgs_pkg.sv
hdl/lgs_ram.sv
hdl/life_generation_step_top.sv
verif/tb_life_generation_step_top.sv
